>>> rtl/psa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the positional shift array: word and field
// widths, command and status codes, and the vacant marker.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 8;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    // Vacant marker: all ones, which is -1 as a signed word.
    localparam logic signed [WORD_W-1:0] VACANT = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_POS = 2'd1,
        CMD_DEL_VAL = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

endpackage
`default_nettype wire

>>> rtl/psa_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_mem
// Entry store: one write port, one read port with registered read data.
// Per-entry valid bits clear at reset; an entry never written reads vacant.
// ----------------------------------------------------------------------------
module psa_mem #(
    parameter int DEPTH = psa_pkg::DEPTH_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             we,
    input  wire logic [IW-1:0]                    waddr,
    input  wire logic signed [psa_pkg::WORD_W-1:0] wdata,
    input  wire logic                             re,
    input  wire logic [IW-1:0]                    raddr,
    output logic signed [psa_pkg::WORD_W-1:0]      rdata
);

    logic signed [psa_pkg::WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]                  valid_reg;
    logic signed [psa_pkg::WORD_W-1:0] data_reg;
    logic                              hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    // Substitute the vacant marker for entries not yet written.
    assign rdata = hit_reg ? data_reg : psa_pkg::VACANT;

endmodule
`default_nettype wire

>>> rtl/positional_shift_array.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_shift_array
// Fixed array of signed 32-bit words in a synchronous memory with positional
// insert, positional delete, delete by first matching value, and read.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------
//  command   start / busy         command, position, value
//  result    done (1-cycle pulse) status, read_value
//
// Steps per beat (p = 1-based position, D = DEPTH):
//   read               : issue, memory read, result
//   insert at p        : shift entries p..D-1 up, then write value at p
//   delete at p        : shift entries p+1..D down, then fill D vacant
//   delete by value    : scan from the first entry to the first match, then
//                        the delete sequence at the hit; no match: NOTFOUND
//   out of range       : range status at once
// The shifts move one entry per cycle through the single memory read port.
// Reset clears the valid bits at once; vacant entries read as -1, so no
// clearing pass is needed. The result is registered and strobed by done in
// the cycle after the last step; the receiver cannot stall it. busy is high
// from the cycle after acceptance to the final step; never if out of range.
//
module positional_shift_array #(
    parameter int DEPTH = psa_pkg::DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [psa_pkg::CMD_W-1:0]          command,
    input  wire logic [psa_pkg::POS_W-1:0]          position,
    input  wire logic signed [psa_pkg::WORD_W-1:0]  value,
    output logic                                    done,
    output logic [psa_pkg::STAT_W-1:0]              status,
    output logic signed [psa_pkg::WORD_W-1:0]       read_value
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_RDATA,
        S_SCAN,
        S_SHDN,
        S_SHUP,
        S_TAIL,
        S_PUT,
        S_FILL
    } state_t;

    state_t                            state_reg, state_next;
    psa_pkg::cmd_t                     cmd_reg, cmd_next;
    logic signed [psa_pkg::WORD_W-1:0] val_reg, val_next;
    logic [IW-1:0]                     idx_reg, idx_next;
    logic [CW-1:0]                     ptr_reg, ptr_next;
    logic                              pend_reg, pend_next;
    logic [IW-1:0]                     pend_addr_reg, pend_addr_next;
    logic                              chk_reg, chk_next;
    logic [IW-1:0]                     chk_addr_reg, chk_addr_next;
    logic                              done_reg, done_next;
    psa_pkg::status_t                  status_reg, status_next;
    logic signed [psa_pkg::WORD_W-1:0] rval_reg, rval_next;

    logic                              mem_we;
    logic [IW-1:0]                     mem_waddr;
    logic signed [psa_pkg::WORD_W-1:0] mem_wdata;
    logic                              mem_re;
    logic [IW-1:0]                     mem_raddr;
    logic signed [psa_pkg::WORD_W-1:0] mem_rdata;

    logic                              accept;
    logic                              pos_ok;
    logic [IW-1:0]                     pos_idx;
    logic                              ptr_in;
    logic                              match;

    assign accept  = start && (state_reg == S_IDLE);
    assign pos_ok  = (position != '0) &&
                     ({1'b0, position} <= (psa_pkg::POS_W + 1)'(DEPTH));
    assign pos_idx = IW'(position - (psa_pkg::POS_W)'(1));
    assign ptr_in  = (ptr_reg < CW'(DEPTH));
    assign match   = chk_reg && (mem_rdata == val_reg);

    psa_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Memory port: a pending shift write lands the word read in the previous
    // cycle; the final insert or vacant fill never overlaps it.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_rdata;
        if (pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            mem_we    = 1'b1;
            mem_waddr = idx_reg;
            mem_wdata = val_reg;
        end
        else if (state_reg == S_FILL)
        begin
            mem_we    = 1'b1;
            mem_waddr = LAST;
            mem_wdata = psa_pkg::VACANT;
        end

        mem_re    = 1'b0;
        mem_raddr = ptr_reg[IW-1:0];
        unique case (state_reg)
            S_READ:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_reg;
            end
            S_SCAN:         mem_re = ptr_in;
            S_SHDN, S_SHUP: mem_re = 1'b1;
            default:        mem_re = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        chk_next       = 1'b0;
        chk_addr_next  = chk_addr_reg;
        done_next      = 1'b0;
        status_next    = psa_pkg::ST_DONE;
        rval_next      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = psa_pkg::cmd_t'(command);
                    val_next = value;
                    idx_next = pos_idx;
                    if (psa_pkg::cmd_t'(command) == psa_pkg::CMD_DEL_VAL)
                    begin
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                    else if (!pos_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = psa_pkg::ST_RANGE;
                    end
                    else
                    begin
                        unique case (psa_pkg::cmd_t'(command))
                            psa_pkg::CMD_INSERT:
                            begin
                                // Walk down from the second-to-last entry.
                                ptr_next   = CW'(LAST) - CW'(1);
                                state_next = (pos_idx == LAST) ? S_PUT : S_SHUP;
                            end
                            psa_pkg::CMD_DEL_POS:
                            begin
                                ptr_next   = CW'(pos_idx) + CW'(1);
                                state_next = (pos_idx == LAST) ? S_FILL : S_SHDN;
                            end
                            default: state_next = S_READ;
                        endcase
                    end
                end
            end
            S_READ:  state_next = S_RDATA;
            S_RDATA:
            begin
                done_next  = 1'b1;
                rval_next  = mem_rdata;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // Compare the word read last cycle; stop at the first hit.
                if (match)
                begin
                    idx_next   = chk_addr_reg;
                    ptr_next   = CW'(chk_addr_reg) + CW'(1);
                    state_next = (chk_addr_reg == LAST) ? S_FILL : S_SHDN;
                end
                else if (chk_reg && (chk_addr_reg == LAST))
                begin
                    done_next   = 1'b1;
                    status_next = psa_pkg::ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else if (ptr_in)
                begin
                    chk_next      = 1'b1;
                    chk_addr_next = ptr_reg[IW-1:0];
                    ptr_next      = ptr_reg + CW'(1);
                end
            end
            S_SHDN:
            begin
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg[IW-1:0] - IW'(1);
                if (ptr_reg[IW-1:0] == LAST)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_SHUP:
            begin
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg[IW-1:0] + IW'(1);
                if (ptr_reg[IW-1:0] == idx_reg)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    ptr_next = ptr_reg - CW'(1);
                end
            end
            S_TAIL:
            begin
                // Drain the last pending shift write.
                state_next = (cmd_reg == psa_pkg::CMD_INSERT) ? S_PUT : S_FILL;
            end
            S_PUT, S_FILL:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= psa_pkg::CMD_INSERT;
            pend_reg      <= 1'b0;
            chk_reg       <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= psa_pkg::ST_DONE;
            rval_reg      <= '0;
            val_reg       <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            pend_addr_reg <= '0;
            chk_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            pend_reg      <= pend_next;
            chk_reg       <= chk_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            rval_reg      <= rval_next;
            val_reg       <= val_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            pend_addr_reg <= pend_addr_next;
            chk_addr_reg  <= chk_addr_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = rval_reg;

    // A shift write never shares the write port with the final write.
    a_wport_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && ((state_reg == S_PUT) || (state_reg == S_FILL))))
        else $error("shift write collides with final write");

    // Read and write never target the same entry in one cycle.
    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("read and write to the same entry");

    // An accepted beat either keeps the block busy or yields a result.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat lost");

    // Only a successful result carries a nonzero word.
    a_rval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != psa_pkg::ST_DONE)) |-> (read_value == '0))
        else $error("failed command returned data");

endmodule
`default_nettype wire
